### src/ole_pkg.sv
// Shared types and codes for the ordered list engine.
`default_nettype none

package ole_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_INSERT = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_NEG_POS   = 3'd2,
        ST_BEYOND    = 3'd3,
        ST_FULL      = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
        logic signed [15:0] position;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [4:0]         item_index;
        logic [4:0]         entry_count;
        logic               last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_CHK,
        S_INS_WR,
        S_INS_DONE,
        S_RM_CHK,
        S_RM_CMP,
        S_CL_CHK,
        S_CL_WR,
        S_RM_DONE,
        S_DP_RD,
        S_DP_OUT
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LEN,
        IDX_ZERO,
        IDX_DEC,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC
    } len_op_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PREV,
        RD_CUR,
        RD_NEXT
    } rd_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_NEW
    } wr_op_t;

    typedef enum logic [1:0] {
        VAL_REQ,
        VAL_MEM,
        VAL_ZERO
    } val_sel_t;

    typedef enum logic [1:0] {
        IX_ZERO,
        IX_CUR,
        IX_HIT
    } ix_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_req;
        idx_op_t  idx_op;
        len_op_t  len_op;
        rd_op_t   rd_op;
        wr_op_t   wr_op;
        logic     save_hit;
        logic     emit;
        status_t  code;
        val_sel_t val_sel;
        ix_sel_t  ix_sel;
        logic     emit_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] opcode;
        logic       pos_neg;
        logic       pos_beyond;
        logic       full;
        logic       empty;
        logic       idx_gt_tgt;
        logic       idx_eq_len;
        logic       match;
        logic       more_close;
        logic       dump_last;
    } sts_t;

endpackage

`default_nettype wire

### src/ole_datapath.sv
// Datapath of the ordered list engine: entry memory, pointers, length and result register.
`default_nettype none

module ole_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ole_pkg::req_t request,
    input  wire ole_pkg::cmd_t cmd,
    output ole_pkg::sts_t      sts,
    output ole_pkg::rsp_t      result,
    output logic               strobe
);
    import ole_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW = (LW > 5) ? LW : 5;

    logic signed [31:0] mem [CAPACITY];

    req_t               req_reg;
    logic [LW-1:0]      idx_reg, idx_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      hit_reg;
    logic signed [31:0] rdata_reg;
    rsp_t               result_reg, result_next;
    logic               strobe_reg;

    logic [LW-1:0] tgt;
    logic [LW-1:0] idx_m1;
    logic [LW-1:0] idx_p1;
    logic [LW-1:0] rd_idx;
    logic [XW-1:0] ix_ext;
    logic [XW-1:0] cnt_ext;

    assign idx_m1 = idx_reg - LW'(1);
    assign idx_p1 = idx_reg + LW'(1);
    assign tgt    = (req_reg.opcode == OP_PUSH) ? '0 : LW'(req_reg.position[14:0]);

    assign sts.opcode     = req_reg.opcode;
    assign sts.pos_neg    = req_reg.position[15];
    assign sts.pos_beyond = {1'b0, req_reg.position[14:0]} > 16'(len_reg);
    assign sts.full       = (len_reg == LW'(CAPACITY));
    assign sts.empty      = (len_reg == '0);
    assign sts.idx_gt_tgt = (idx_reg > tgt);
    assign sts.idx_eq_len = (idx_reg == len_reg);
    assign sts.match      = (rdata_reg == req_reg.value);
    assign sts.more_close = (idx_p1 < len_reg);
    assign sts.dump_last  = (idx_p1 == len_reg);

    always_comb
    begin
        unique case (cmd.idx_op)
            IDX_LEN:  idx_next = len_reg;
            IDX_ZERO: idx_next = '0;
            IDX_DEC:  idx_next = idx_m1;
            IDX_INC:  idx_next = idx_p1;
            default:  idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.len_op)
            LEN_INC: len_next = len_reg + LW'(1);
            LEN_DEC: len_next = len_reg - LW'(1);
            default: len_next = len_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_op)
            RD_PREV: rd_idx = idx_m1;
            RD_NEXT: rd_idx = idx_p1;
            default: rd_idx = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            len_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= request;
        end
        if (cmd.save_hit)
        begin
            hit_reg <= idx_reg;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_op == WR_SHIFT)
        begin
            mem[idx_reg[AW-1:0]] <= rdata_reg;
        end
        else if (cmd.wr_op == WR_NEW)
        begin
            mem[idx_reg[AW-1:0]] <= req_reg.value;
        end
        if (cmd.rd_op != RD_NONE)
        begin
            rdata_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    always_comb
    begin
        unique case (cmd.ix_sel)
            IX_CUR:  ix_ext = XW'(idx_reg);
            IX_HIT:  ix_ext = XW'(hit_reg);
            default: ix_ext = '0;
        endcase
        cnt_ext = XW'(len_reg);

        result_next.status      = cmd.code;
        result_next.item_index  = ix_ext[4:0];
        result_next.entry_count = cnt_ext[4:0];
        result_next.last        = cmd.emit_last;
        unique case (cmd.val_sel)
            VAL_MEM:  result_next.item_value = rdata_reg;
            VAL_ZERO: result_next.item_value = '0;
            default:  result_next.item_value = req_reg.value;
        endcase
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

### src/ole_ctrl.sv
// Controller state machine of the ordered list engine.
`default_nettype none

module ole_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire ole_pkg::sts_t sts,
    output ole_pkg::cmd_t      cmd,
    output logic               busy
);
    import ole_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (sts.opcode == OP_REMOVE)
                    state_next = S_RM_CHK;
                else if (sts.opcode == OP_DUMP)
                    state_next = sts.empty ? S_IDLE : S_DP_RD;
                else if (sts.opcode == OP_INSERT && (sts.pos_neg || sts.pos_beyond))
                    state_next = S_IDLE;
                else if (sts.full)
                    state_next = S_IDLE;
                else
                    state_next = S_INS_CHK;
            end
            S_INS_CHK:  state_next = sts.idx_gt_tgt ? S_INS_WR : S_INS_DONE;
            S_INS_WR:   state_next = S_INS_CHK;
            S_INS_DONE: state_next = S_IDLE;
            S_RM_CHK:   state_next = sts.idx_eq_len ? S_IDLE : S_RM_CMP;
            S_RM_CMP:   state_next = sts.match ? S_CL_CHK : S_RM_CHK;
            S_CL_CHK:   state_next = sts.more_close ? S_CL_WR : S_RM_DONE;
            S_CL_WR:    state_next = S_CL_CHK;
            S_RM_DONE:  state_next = S_IDLE;
            S_DP_RD:    state_next = S_DP_OUT;
            S_DP_OUT:   state_next = sts.dump_last ? S_IDLE : S_DP_RD;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load_req  = 1'b0;
        cmd.idx_op    = IDX_HOLD;
        cmd.len_op    = LEN_HOLD;
        cmd.rd_op     = RD_NONE;
        cmd.wr_op     = WR_NONE;
        cmd.save_hit  = 1'b0;
        cmd.emit      = 1'b0;
        cmd.code      = ST_OK;
        cmd.val_sel   = VAL_REQ;
        cmd.ix_sel    = IX_ZERO;
        cmd.emit_last = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_req = start;
            end
            S_DECIDE:
            begin
                priority if (sts.opcode == OP_REMOVE)
                begin
                    cmd.idx_op = IDX_ZERO;
                end
                else if (sts.opcode == OP_DUMP)
                begin
                    cmd.idx_op = IDX_ZERO;
                    if (sts.empty)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.code    = ST_EMPTY;
                        cmd.val_sel = VAL_ZERO;
                    end
                end
                else if (sts.opcode == OP_INSERT && sts.pos_neg)
                begin
                    cmd.emit = 1'b1;
                    cmd.code = ST_NEG_POS;
                end
                else if (sts.opcode == OP_INSERT && sts.pos_beyond)
                begin
                    cmd.emit = 1'b1;
                    cmd.code = ST_BEYOND;
                end
                else if (sts.full)
                begin
                    cmd.emit = 1'b1;
                    cmd.code = ST_FULL;
                end
                else
                begin
                    cmd.idx_op = IDX_LEN;
                end
            end
            S_INS_CHK:
            begin
                if (sts.idx_gt_tgt)
                begin
                    cmd.rd_op = RD_PREV;
                end
                else
                begin
                    cmd.wr_op  = WR_NEW;
                    cmd.len_op = LEN_INC;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_op  = WR_SHIFT;
                cmd.idx_op = IDX_DEC;
            end
            S_INS_DONE:
            begin
                cmd.emit   = 1'b1;
                cmd.ix_sel = IX_CUR;
            end
            S_RM_CHK:
            begin
                if (sts.idx_eq_len)
                begin
                    cmd.emit = 1'b1;
                    cmd.code = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.rd_op = RD_CUR;
                end
            end
            S_RM_CMP:
            begin
                if (sts.match)
                begin
                    cmd.save_hit = 1'b1;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_CL_CHK:
            begin
                if (sts.more_close)
                begin
                    cmd.rd_op = RD_NEXT;
                end
                else
                begin
                    cmd.len_op = LEN_DEC;
                end
            end
            S_CL_WR:
            begin
                cmd.wr_op  = WR_SHIFT;
                cmd.idx_op = IDX_INC;
            end
            S_RM_DONE:
            begin
                cmd.emit   = 1'b1;
                cmd.ix_sel = IX_HIT;
            end
            S_DP_RD:
            begin
                cmd.rd_op = RD_CUR;
            end
            S_DP_OUT:
            begin
                cmd.emit      = 1'b1;
                cmd.val_sel   = VAL_MEM;
                cmd.ix_sel    = IX_CUR;
                cmd.emit_last = sts.dump_last;
                cmd.idx_op    = IDX_INC;
            end
            default:
            begin
                cmd.load_req = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### src/ordered_list_engine_unit.sv
// Top level of the ordered list engine: controller plus datapath.
//
//  channel   | ports                    | handshake
//  ----------+--------------------------+-------------------------------------
//  request   | start, busy, request     | taken on a clock edge with start high, busy low
//  result    | strobe, result           | shown for one cycle, no backpressure
//
// Each request is captured in idle and checked in the decide state; a rejected one ends there. Push
// and insert move each entry behind the target back by a read and a write, then write the new entry;
// remove compares entries until a match or the end, then moves each later entry forward; dump shows each.
// The entry memory allows one registered read and one write per cycle.
// Reset clears the length and the controller; entries are never read before written.
// No stalls: each result shows on strobe for one cycle; busy falls as the last is registered.
`default_nettype none

module ordered_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ole_pkg::req_t request,
    output logic               strobe,
    output ole_pkg::rsp_t      result
);
    import ole_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence each request: checks, shift loops, search and dump walk.
    ole_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold the entries, length and pointers; register each result.
    ole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result),
        .strobe  (strobe)
    );

endmodule

`default_nettype wire
